@@ rtl/core/spfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfd_pkg
// Shared widths, status codes and helpers for the sensor pulse frame decoder.
// ----------------------------------------------------------------------------
package spfd_pkg;

    localparam int PULSE_TIME_BITS   = 15;
    localparam int THRESHOLD_BITS    = 15;
    localparam int CMP_BITS          = 17;
    localparam int FRAME_BITS        = 40;
    localparam int COUNT_BITS        = 6;
    localparam int STATUS_BITS       = 2;
    localparam int VALUE_BITS        = 12;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET   = THRESHOLD_BITS'(35);
    localparam logic [COUNT_BITS-1:0]     DATA_PULSES       = COUNT_BITS'(40);
    localparam logic [COUNT_BITS-1:0]     FULL_FRAME_PULSES = COUNT_BITS'(41);

    localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_SHORT   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_BAD_SUM = 2'd2;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = VALUE_BITS'(2805);

    typedef logic [PULSE_TIME_BITS-1:0] pulse_time_t;
    typedef logic [THRESHOLD_BITS-1:0]  threshold_t;
    typedef logic [STATUS_BITS-1:0]     status_t;
    typedef logic [VALUE_BITS-1:0]      value_t;

    // high byte times ten plus low byte
    function automatic value_t decode_x10(input logic [15:0] word);
        value_t hi;
        value_t lo;
        begin
            hi = VALUE_BITS'(word[15:8]);
            lo = VALUE_BITS'(word[7:0]);
            decode_x10 = (hi << 3) + (hi << 1) + lo;
        end
    endfunction

endpackage

@@ rtl/core/sensor_pulse_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_pulse_frame_decoder
// Decodes pulse high times of a 40-bit sensor frame into checked readings.
// ----------------------------------------------------------------------------
// One pulse request is taken every clock cycle. A pulse goes into an input
// register, and in the next cycle its bit is compared against the threshold,
// shifted into the frame and counted; a pulse marked frame end then loads the
// result register from the input register, and the result is held there until
// it is accepted. The only stall is a frame end pulse that meets a result still
// waiting in the result register. The threshold is written through the cfg
// channel, which is always ready; the user must write it only while no pulses
// are in flight, as the block itself does not enforce this.
module sensor_pulse_frame_decoder
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  spfd_pkg::threshold_t           one_bit_threshold,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  spfd_pkg::pulse_time_t          pulse_high_time,
    input  logic                           frame_end,
    output logic                           out_valid,
    input  logic                           out_ready,
    output spfd_pkg::status_t              status,
    output spfd_pkg::value_t               humidity_x10,
    output spfd_pkg::value_t               temperature_x10
);
    import spfd_pkg::*;

    threshold_t                thr_reg;
    logic                      s1_valid_reg;
    pulse_time_t               s1_time_reg;
    logic                      s1_end_reg;
    logic [FRAME_BITS-1:0]     frame_reg;
    logic [FRAME_BITS-1:0]     frame_next;
    logic [COUNT_BITS-1:0]     count_reg;
    logic [COUNT_BITS-1:0]     count_next;
    logic                      out_valid_reg;
    status_t                   status_reg;
    value_t                    hum_reg;
    value_t                    temp_reg;

    logic                      s1_advance;
    logic                      bit_val;
    logic [FRAME_BITS-1:0]     frame_upd;
    logic [COUNT_BITS-1:0]     count_upd;
    logic [7:0]                sum;
    status_t                   status_next;
    value_t                    hum_next;
    value_t                    temp_next;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!s1_end_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_comb
    begin
        bit_val = CMP_BITS'(s1_time_reg) >= CMP_BITS'(thr_reg);
        frame_upd = frame_reg;
        if (count_reg < DATA_PULSES)
        begin
            frame_upd = {frame_reg[FRAME_BITS-2:0], bit_val};
        end
        count_upd = count_reg;
        if (count_reg < FULL_FRAME_PULSES)
        begin
            count_upd = count_reg + COUNT_BITS'(1);
        end
        sum = frame_upd[39:32] + frame_upd[31:24] + frame_upd[23:16] + frame_upd[15:8];
        status_next = STATUS_OK;
        hum_next    = '0;
        temp_next   = '0;
        if (count_upd < FULL_FRAME_PULSES)
        begin
            status_next = STATUS_SHORT;
        end
        else if (sum != frame_upd[7:0])
        begin
            status_next = STATUS_BAD_SUM;
        end
        else
        begin
            hum_next  = decode_x10(frame_upd[39:24]);
            temp_next = decode_x10(frame_upd[23:8]);
        end
        frame_next = frame_reg;
        count_next = count_reg;
        if (s1_advance)
        begin
            frame_next = s1_end_reg ? '0 : frame_upd;
            count_next = s1_end_reg ? '0 : count_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            s1_valid_reg  <= 1'b0;
            frame_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= one_bit_threshold;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            frame_reg <= frame_next;
            count_reg <= count_next;
            if (s1_advance && s1_end_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_time_reg <= pulse_high_time;
            s1_end_reg  <= frame_end;
        end
        if (s1_advance && s1_end_reg)
        begin
            status_reg <= status_next;
            hum_reg    <= hum_next;
            temp_reg   <= temp_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign humidity_x10    = hum_reg;
    assign temperature_x10 = temp_reg;

endmodule

@@ rtl/core/spfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfd_checker
// Port-level assertions for the sensor pulse frame decoder, bound to the top.
// ----------------------------------------------------------------------------
module spfd_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  spfd_pkg::status_t     status,
    input  spfd_pkg::value_t      humidity_x10,
    input  spfd_pkg::value_t      temperature_x10
);
    import spfd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(humidity_x10) && $stable(temperature_x10))
        else $error("result changed while stalled");

    // readings are zero unless the frame checked out
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> humidity_x10 == '0 && temperature_x10 == '0)
        else $error("nonzero reading on failed frame");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_OK || status == STATUS_SHORT
            || status == STATUS_BAD_SUM)
        else $error("undefined status code");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK |-> humidity_x10 <= VALUE_MAX
            && temperature_x10 <= VALUE_MAX)
        else $error("reading out of range");

endmodule

bind sensor_pulse_frame_decoder spfd_checker u_spfd_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .humidity_x10    (humidity_x10),
    .temperature_x10 (temperature_x10)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor pulse frame decoder. A table of directed
// frames covers short frames, all-zero and all-one data, checksum errors and
// pulse count saturation. Random frames follow under several threshold
// settings. Both handshakes idle at random, and each reading is checked
// against its expected table entry or, for other frames, an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import spfd_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DIRECTED_FRAMES = 11;
    localparam int PHASE_PULSES    = 90;
    localparam int PHASE_FRAMES    = 2;
    localparam int TIME_MAX        = (1 << PULSE_TIME_BITS) - 1;

    typedef struct packed {
        status_t st;
        value_t  hum;
        value_t  temp;
    } reading_t;

    typedef struct {
        int unsigned      pulses;
        logic [39:0]      bits;
        pulse_time_t      zero_time;
        pulse_time_t      one_time;
        bit               typed;
        reading_t         want;
    } frame_case_t;

    typedef enum int { TIMES_FIXED, TIMES_SPREAD, TIMES_NOISE } time_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    threshold_t  one_bit_threshold;
    logic        in_valid;
    logic        in_ready;
    pulse_time_t pulse_high_time;
    logic        frame_end;
    logic        out_valid;
    logic        out_ready;
    status_t     status;
    value_t      humidity_x10;
    value_t      temperature_x10;

    logic [39:0]      model_bits;
    logic [5:0]       model_count;
    threshold_t       model_threshold;
    reading_t         pending_readings[$];
    int               errors = 0;
    int               pulses_sent;
    int               ok_frames = 0;
    int               short_frames = 0;
    int               bad_sum_frames = 0;
    int               settings_used;
    int               cycle_count = 0;
    bit               calm;

    // short frames, extremes, threshold edge, checksum error, count saturation
    frame_case_t directed_frames [DIRECTED_FRAMES] = '{
        '{1,  40'h00_0000_0000, 15'd0,  15'd32767, 1'b1, '{STATUS_SHORT,   12'd0,    12'd0}},
        '{1,  40'h80_0000_0000, 15'd0,  15'd32767, 1'b1, '{STATUS_SHORT,   12'd0,    12'd0}},
        '{40, 40'hFF_FFFF_FFFC, 15'd0,  15'd32767, 1'b1, '{STATUS_SHORT,   12'd0,    12'd0}},
        '{41, 40'h00_0000_0000, 15'd0,  15'd32767, 1'b1, '{STATUS_OK,      12'd0,    12'd0}},
        '{41, 40'hFF_FFFF_FFFC, 15'd34, 15'd35,    1'b1, '{STATUS_OK,      12'd2805, 12'd2805}},
        '{41, 40'hFF_FFFF_FFFD, 15'd34, 15'd35,    1'b1, '{STATUS_BAD_SUM, 12'd0,    12'd0}},
        '{42, 40'h32_0019_004B, 15'd0,  15'd32767, 1'b1, '{STATUS_OK,      12'd500,  12'd250}},
        '{70, 40'h32_0019_004B, 15'd0,  15'd32767, 1'b1, '{STATUS_OK,      12'd500,  12'd250}},
        '{50, 40'h0A_0514_0326, 15'd1,  15'd1000,  1'b1, '{STATUS_OK,      12'd105,  12'd203}},
        '{41, 40'h12_3456_7814, 15'd17, 15'd36,    1'b0, '{STATUS_OK,      12'd0,    12'd0}},
        '{41, 40'h01_FF00_8000, 15'd0,  15'd32767, 1'b0, '{STATUS_OK,      12'd0,    12'd0}}
    };

    sensor_pulse_frame_decoder i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .one_bit_threshold (one_bit_threshold),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pulse_high_time (pulse_high_time),
        .frame_end       (frame_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .humidity_x10    (humidity_x10),
        .temperature_x10 (temperature_x10)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int idle_cycles();
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic value_t bytes_x10(input logic [15:0] word);
        return value_t'(word[15:8]) * value_t'(10) + value_t'(word[7:0]);
    endfunction

    function automatic bit predict_pulse(input pulse_time_t t, input logic fe,
                                         output reading_t r);
        logic [15:0] rh;
        logic [15:0] tp;
        logic [7:0]  sum;
        r = '0;
        if (model_count < DATA_PULSES)
            model_bits = {model_bits[38:0], t >= model_threshold};
        if (model_count < FULL_FRAME_PULSES)
            model_count = model_count + 6'd1;
        if (!fe)
            return 1'b0;
        rh  = model_bits[39:24];
        tp  = model_bits[23:8];
        sum = rh[15:8] + rh[7:0] + tp[15:8] + tp[7:0];
        if (model_count < FULL_FRAME_PULSES)
            r.st = STATUS_SHORT;
        else if (sum != model_bits[7:0])
            r.st = STATUS_BAD_SUM;
        else
        begin
            r.st   = STATUS_OK;
            r.hum  = bytes_x10(rh);
            r.temp = bytes_x10(tp);
        end
        model_bits  = '0;
        model_count = '0;
        return 1'b1;
    endfunction

    function automatic pulse_time_t time_for_bit(input logic b);
        if (b)
            return pulse_time_t'($urandom_range(model_threshold, TIME_MAX));
        if (model_threshold == 0)
            return pulse_time_t'($urandom_range(0, TIME_MAX));
        return pulse_time_t'($urandom_range(0, model_threshold - 1));
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_pulse(input pulse_time_t t, input logic fe, input bit typed,
                              input reading_t want);
        int       gap;
        reading_t predicted;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        pulse_high_time <= t;
        frame_end       <= fe;
        do
            @(posedge clk);
        while (!in_ready);
        pulses_sent++;
        if (predict_pulse(t, fe, predicted))
            pending_readings.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [39:0] bits, input int unsigned pulses,
                              input time_mode_t mode, input pulse_time_t zero_time,
                              input pulse_time_t one_time, input bit typed,
                              input reading_t want);
        pulse_time_t t;
        logic        b;
        for (int unsigned i = 0; i < pulses; i++)
        begin
            b = (i < 40) ? bits[39 - i] : 1'b1;
            case (mode)
                TIMES_FIXED:  t = b ? one_time : zero_time;
                TIMES_SPREAD: t = (i < 40) ? time_for_bit(b)
                                           : pulse_time_t'($urandom_range(0, TIME_MAX));
                default:      t = pulse_time_t'($urandom_range(0, TIME_MAX));
            endcase
            send_pulse(t, i == pulses - 1, typed, want);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0]  rh_hi;
        logic [7:0]  rh_lo;
        logic [7:0]  tp_hi;
        logic [7:0]  tp_lo;
        logic [7:0]  sum;
        int unsigned pulses;
        int          pick;
        time_mode_t  mode;
        rh_hi = 8'($urandom_range(0, 255));
        rh_lo = 8'($urandom_range(0, 255));
        tp_hi = 8'($urandom_range(0, 255));
        tp_lo = 8'($urandom_range(0, 255));
        sum   = rh_hi + rh_lo + tp_hi + tp_lo;
        if ($urandom_range(0, 4) == 0)
            sum = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 65)
            pulses = 41;
        else if (pick < 80)
            pulses = $urandom_range(42, 70);
        else
            pulses = $urandom_range(1, 40);
        mode = ($urandom_range(0, 9) == 0) ? TIMES_NOISE : TIMES_SPREAD;
        send_frame({rh_hi, rh_lo, tp_hi, tp_lo, sum}, pulses, mode, '0, '0, 1'b0, '0);
    endtask

    task automatic wait_for_readings();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_threshold(input threshold_t value);
        wait_for_readings();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid         <= 1'b1;
        one_bit_threshold <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_threshold = value;
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            @(negedge clk);
            stall = idle_cycles();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : check_reading
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status == STATUS_OK)
                ok_frames++;
            else if (status == STATUS_SHORT)
                short_frames++;
            else
                bad_sum_frames++;
            if (pending_readings.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reading status %0d humidity %0d temperature %0d",
                         $time, status, humidity_x10, temperature_x10);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (status !== want.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                end
                if (humidity_x10 !== want.hum)
                begin
                    errors++;
                    $display("%0t: humidity_x10 expected %0d actual %0d",
                             $time, want.hum, humidity_x10);
                end
                if (temperature_x10 !== want.temp)
                begin
                    errors++;
                    $display("%0t: temperature_x10 expected %0d actual %0d",
                             $time, want.temp, temperature_x10);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d readings outstanding", $time,
                     pending_readings.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        threshold_t  settings [5];
        int          phase_start;
        int          frames;
        rst_n             = 1'b0;
        cfg_valid         = 1'b0;
        one_bit_threshold = '0;
        in_valid          = 1'b0;
        pulse_high_time   = '0;
        frame_end         = 1'b0;
        model_bits        = '0;
        model_count       = '0;
        model_threshold   = THRESHOLD_RESET;
        pulses_sent       = 0;
        settings_used     = 1;
        calm              = 1'b0;
        settings[0] = threshold_t'(0);
        settings[1] = threshold_t'(TIME_MAX);
        settings[2] = threshold_t'(1);
        settings[3] = threshold_t'($urandom_range(2, TIME_MAX - 1));
        settings[4] = THRESHOLD_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_frames[i])
            send_frame(directed_frames[i].bits, directed_frames[i].pulses, TIMES_FIXED,
                       directed_frames[i].zero_time, directed_frames[i].one_time,
                       directed_frames[i].typed, directed_frames[i].want);

        for (int phase = 0; phase <= 5; phase++)
        begin
            if (phase > 0)
                write_threshold(settings[phase - 1]);
            calm        = (phase % 3 == 1);
            phase_start = pulses_sent;
            frames      = 0;
            while (pulses_sent - phase_start < PHASE_PULSES || frames < PHASE_FRAMES)
            begin
                send_random_frame();
                frames++;
                if ($urandom_range(0, 7) == 0)
                    wait_for_readings();
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("%0d pulses under %0d threshold settings gave %0d ok frames,",
                 pulses_sent, settings_used, ok_frames);
        $display("%0d short frames and %0d checksum failures", short_frames, bad_sum_frames);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/spfd_pkg.sv
rtl/core/sensor_pulse_frame_decoder.sv
rtl/core/spfd_checker.sv
bench/tb_top.sv
